### rtl/ttce_pkg.sv
// Shared types and constants for the text terminal cursor engine.
// Holds the screen geometry, byte codes, cell and payload structs.
// No dependencies.
`default_nettype none

package ttce_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_STEP   = 4;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [3:0] NIB_FG       = 4'hF;
  localparam logic [3:0] NIB_BG       = 4'hB;
  localparam logic [3:0] RESET_FG     = 4'd7;
  localparam logic [3:0] RESET_BG     = 4'd0;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [7:0] ch;
    logic [3:0] fg;
    logic [3:0] bg;
  } cell_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [7:0]       char_byte;
    logic [COL_W-1:0] read_col;
    logic [ROW_W-1:0] read_row;
  } in_t;

  typedef struct packed {
    logic [COL_W-1:0] cursor_column;
    logic [ROW_W-1:0] cursor_line;
    logic [7:0]       cell_char;
    logic [3:0]       cell_fg;
    logic [3:0]       cell_bg;
    logic             scrolled;
  } out_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    cell_addr = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

`default_nettype wire

### rtl/ttce_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// A read of the address being written returns the new data. No dependencies.
`default_nettype none

module ttce_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [DATA_W-1:0]        wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### rtl/text_terminal_cursor_engine_core.sv
// Text terminal cursor engine: screen store in one RAM, cursor and colors in
// registers, a sequencer for put, read, clear and scroll. Uses ttce_pkg, ttce_ram.
//
//   channel | ports                          | payload
//   input   | in_valid, in_ready, in_data    | in_t  (cmd, char_byte, read_col, read_row)
//   result  | out_valid, out_ready, out_data | out_t (cursor, cell fields, scrolled)
//
// An item is accepted in ST_IDLE and executed in ST_EXEC; a read also passes
// through ST_RDWAIT for the registered RAM read. A scroll walks the store once
// through the single RAM port pair; a clear blanks the store in ST_FILL.
// After reset a fill pass blanks the store, in_ready low.
// Execution waits while the result register is full and out_ready is low;
// a new item is still accepted while a finished result waits.
`default_nettype none

module text_terminal_cursor_engine_core
  import ttce_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  typedef enum logic [6:0] {
    ST_INIT   = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_EXEC   = 7'b0000100,
    ST_RDWAIT = 7'b0001000,
    ST_COPY   = 7'b0010000,
    ST_BLANK  = 7'b0100000,
    ST_FILL   = 7'b1000000
  } state_t;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_COUNT - 1);

  state_t            state_r, state_nxt;
  in_t               item_r, item_nxt;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [3:0]        fg_r, fg_nxt;
  logic [3:0]        bg_r, bg_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic              pend_r, pend_nxt;
  logic              pend_copy_r, pend_copy_nxt;
  logic [ADDR_W-1:0] pend_addr_r, pend_addr_nxt;
  cell_t             pend_data_r, pend_data_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_r, out_nxt;

  logic              ram_rd_en;
  logic [ADDR_W-1:0] ram_rd_addr;
  logic [15:0]       ram_rd_raw;
  cell_t             ram_rd_data;
  cell_t             ram_wr_data;

  logic              slot_free;
  logic              res_load;
  cell_t             blank;

  // Put decode results.
  logic [COL_W:0]    put_col;
  logic [ROW_W:0]    put_row;
  logic [3:0]        put_fg;
  logic [3:0]        put_bg;
  logic              put_wr;
  logic              put_scroll;

  ttce_ram #(
    .DATA_W (16),
    .DEPTH  (CELL_COUNT)
  ) u_screen (
    .clk     (clk),
    .wr_en   (pend_r),
    .wr_addr (pend_addr_r),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_raw)
  );

  assign ram_rd_data = cell_t'(ram_rd_raw);
  // A copy transfer writes the word that was read in the previous cycle.
  assign ram_wr_data = pend_copy_r ? ram_rd_data : pend_data_r;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign slot_free = !out_valid_r || out_ready;
  assign blank     = '{ch: CH_SPACE, fg: fg_r, bg: bg_r};

  always_comb begin
    put_col    = {1'b0, cur_col_r};
    put_row    = {1'b0, cur_row_r};
    put_fg     = fg_r;
    put_bg     = bg_r;
    put_wr     = 1'b0;
    put_scroll = 1'b0;
    priority if (item_r.char_byte == CH_NEWLINE) begin
      put_row = put_row + (ROW_W+1)'(1);
      put_col = '0;
    end else if (item_r.char_byte == CH_TAB) begin
      put_col = put_col + (COL_W+1)'(TAB_STEP);
    end else if (item_r.char_byte == CH_BACKSPACE) begin
      if (put_col != '0) begin
        put_col = put_col - (COL_W+1)'(1);
      end
    end else if (item_r.char_byte[7]) begin
      if (item_r.char_byte[7:4] == NIB_FG) begin
        put_fg = item_r.char_byte[3:0];
      end else if (item_r.char_byte[7:4] == NIB_BG) begin
        put_bg = item_r.char_byte[3:0];
      end
    end else begin
      put_wr  = 1'b1;
      put_col = put_col + (COL_W+1)'(1);
    end
    if (put_col >= (COL_W+1)'(COLUMNS)) begin
      put_col = '0;
      put_row = put_row + (ROW_W+1)'(1);
    end
    if (put_row >= (ROW_W+1)'(ROWS)) begin
      put_scroll = 1'b1;
      put_col    = '0;
      put_row    = (ROW_W+1)'(ROWS - 1);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    fg_nxt        = fg_r;
    bg_nxt        = bg_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = 1'b0;
    pend_copy_nxt = 1'b0;
    pend_addr_nxt = pend_addr_r;
    pend_data_nxt = pend_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = cnt_r;
    res_load      = 1'b0;

    unique case (state_r)
      ST_INIT: begin
        pend_nxt      = 1'b1;
        pend_addr_nxt = cnt_r;
        pend_data_nxt = blank;
        if (cnt_r == LAST_ADDR) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // Once past this point the result register stays free until loaded.
        if (slot_free) begin
          unique case (item_r.cmd)
            CMD_PUT: begin
              cur_col_nxt = put_col[COL_W-1:0];
              cur_row_nxt = put_row[ROW_W-1:0];
              fg_nxt      = put_fg;
              bg_nxt      = put_bg;
              if (put_wr) begin
                pend_nxt      = 1'b1;
                pend_addr_nxt = cell_addr(cur_row_r, cur_col_r);
                pend_data_nxt = '{ch: item_r.char_byte, fg: put_fg, bg: put_bg};
              end
              if (put_scroll) begin
                cnt_nxt   = ADDR_W'(COLUMNS);
                state_nxt = ST_COPY;
              end else begin
                res_load  = 1'b1;
                out_nxt   = '{cursor_column: put_col[COL_W-1:0],
                              cursor_line: put_row[ROW_W-1:0],
                              default: '0};
                state_nxt = ST_IDLE;
              end
            end
            CMD_READ: begin
              if ((item_r.read_col < COL_W'(COLUMNS)) &&
                  (item_r.read_row < ROW_W'(ROWS))) begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = cell_addr(item_r.read_row, item_r.read_col);
                state_nxt   = ST_RDWAIT;
              end else begin
                res_load  = 1'b1;
                out_nxt   = '{cursor_column: cur_col_r, cursor_line: cur_row_r,
                              default: '0};
                state_nxt = ST_IDLE;
              end
            end
            CMD_CLEAR: begin
              cur_col_nxt = '0;
              cur_row_nxt = '0;
              cnt_nxt     = '0;
              state_nxt   = ST_FILL;
            end
            default: begin
              res_load  = 1'b1;
              out_nxt   = '{cursor_column: cur_col_r, cursor_line: cur_row_r,
                            default: '0};
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_RDWAIT: begin
        res_load  = 1'b1;
        out_nxt   = '{cursor_column: cur_col_r, cursor_line: cur_row_r,
                      cell_char: ram_rd_data.ch, cell_fg: ram_rd_data.fg,
                      cell_bg: ram_rd_data.bg, scrolled: 1'b0};
        state_nxt = ST_IDLE;
      end
      ST_COPY: begin
        // Read row r+1 now, write it to row r in the next cycle.
        ram_rd_en     = 1'b1;
        ram_rd_addr   = cnt_r;
        pend_nxt      = 1'b1;
        pend_copy_nxt = 1'b1;
        pend_addr_nxt = cnt_r - ADDR_W'(COLUMNS);
        if (cnt_r == LAST_ADDR) begin
          cnt_nxt   = ADDR_W'(CELL_COUNT - COLUMNS);
          state_nxt = ST_BLANK;
        end else begin
          cnt_nxt = cnt_r + ADDR_W'(1);
        end
      end
      ST_BLANK, ST_FILL: begin
        pend_nxt      = 1'b1;
        pend_addr_nxt = cnt_r;
        pend_data_nxt = blank;
        if (cnt_r == LAST_ADDR) begin
          cnt_nxt   = '0;
          res_load  = 1'b1;
          out_nxt   = '{cursor_column: cur_col_r, cursor_line: cur_row_r,
                        scrolled: (state_r == ST_BLANK), default: '0};
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + ADDR_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (res_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      fg_r        <= RESET_FG;
      bg_r        <= RESET_BG;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      fg_r        <= fg_nxt;
      bg_r        <= bg_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    pend_copy_r <= pend_copy_nxt;
    pend_addr_r <= pend_addr_nxt;
    pend_data_r <= pend_data_nxt;
    out_r       <= out_nxt;
  end

`ifndef SYNTHESIS
  a_exec_no_pending_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |-> !pend_r)
    else $error("pending store write overlaps item execution");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_col_r < COL_W'(COLUMNS)) && (cur_row_r < ROW_W'(ROWS)))
    else $error("cursor left the screen");

  a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> slot_free)
    else $error("result register overwritten before transfer");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.scrolled) |->
      ((out_r.cursor_column == '0) && (out_r.cursor_line == ROW_W'(ROWS - 1))))
    else $error("scroll result with cursor off the bottom row start");
`endif

endmodule

`default_nettype wire
